// ===== rtl/core/rc5_pkg.sv =====
// Shared types, constants and datapath control encoding for the RC5 block cipher.
`default_nettype none

package rc5_pkg;

    // Default round count of RC5-32/12/16.
    localparam int unsigned ROUNDS_DEF = 12;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BLOCK_W   = 64;
    localparam int unsigned KEY_REG_W = 64;
    localparam int unsigned KEY_WORDS = 4;
    localparam int unsigned ROT_W     = 5;
    localparam int unsigned CFG_IDX_W = 4;

    // Magic constants of the key schedule.
    localparam logic [WORD_W-1:0] MAGIC_P = 32'hB7E15163;
    localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9E3779B9;

    // Fixed left rotation applied to round-key words while mixing.
    localparam logic [ROT_W-1:0] KEY_ROT = 5'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 4'd1;

    typedef logic [WORD_W-1:0] t_word;

    // Operation applied to the two operands ahead of the rotator.
    typedef enum logic [1:0] {
        PRE_XOR,
        PRE_ADD,
        PRE_SUB
    } t_pre_op;

    // Control word of the shared datapath unit.
    typedef struct packed {
        t_pre_op pre;
        logic    rot_right;
        logic    post_xor;
    } t_alu_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/rc5_alu.sv =====
// Shared RC5 datapath unit: add, subtract or xor, then a variable rotate, then an optional xor.
`default_nettype none

module rc5_alu (
    input  rc5_pkg::t_alu_ctl           i_ctl,
    input  rc5_pkg::t_word              i_x,
    input  rc5_pkg::t_word              i_y,
    input  rc5_pkg::t_word              i_z,
    input  logic [rc5_pkg::ROT_W-1:0]   i_amt,
    output rc5_pkg::t_word              o_res
);
    import rc5_pkg::*;

    t_word               pre;
    t_word               rot;
    logic [2*WORD_W-1:0] dbl_l;
    logic [2*WORD_W-1:0] dbl_r;

    always_comb begin
        unique case (i_ctl.pre)
            PRE_XOR: pre = i_x ^ i_y;
            PRE_ADD: pre = i_x + i_y;
            PRE_SUB: pre = i_x - i_y;
            default: pre = i_x ^ i_y;
        endcase

        // Rotating a doubled word by zero leaves the word unchanged.
        dbl_l = {pre, pre} << i_amt;
        dbl_r = {pre, pre} >> i_amt;
        rot   = i_ctl.rot_right ? dbl_r[WORD_W-1:0] : dbl_l[2*WORD_W-1:WORD_W];
        o_res = i_ctl.post_xor ? (rot ^ i_z) : rot;
    end

endmodule

`default_nettype wire

// ===== rtl/core/rc5_block_cipher.sv =====
// Top level of the RC5-32 block cipher with key expansion and one shared datapath unit.
//
//  Channel   | Direction | Handshake                     | Payload
//  ----------+-----------+-------------------------------+------------------------------
//  command   | in        | start high while busy is low  | i_operation, i_data_in
//  result    | out       | o_done strobe, one cycle      | o_data_out
//  config    | in        | i_cfg_valid and o_cfg_ready   | i_cfg_index, i_cfg_data
//
// An encrypt transaction keeps busy high through the whitening additions and, in each round,
// the xor-rotate of A, the key addition to A, the xor-rotate of B and the key addition to B;
// a decrypt transaction through a B step and an A step in each round and then the final
// whitening subtractions. Every step is one pass through the shared add/rotate/xor unit with
// one round-key read from the table memory. The result strobe rises on the same edge at
// which busy falls, so a new command can be taken while the strobe is high. The receiver
// cannot stall the result. After reset and after every write to a key register the table
// is rebuilt: a fill, then 3*(2*ROUNDS+2) mixing steps, with busy high and o_cfg_ready low.
`default_nettype none

module rc5_block_cipher #(
    parameter int unsigned ROUNDS = rc5_pkg::ROUNDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_operation,
    input  logic [rc5_pkg::BLOCK_W-1:0]     i_data_in,
    output logic                            o_done,
    output logic [rc5_pkg::BLOCK_W-1:0]     o_data_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rc5_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rc5_pkg::KEY_REG_W-1:0]   i_cfg_data
);
    import rc5_pkg::*;

    // Table size and most counter widths follow from the round count; UW follows KEY_WORDS.
    localparam int unsigned TW        = 2 * ROUNDS + 2;
    localparam int unsigned IW        = $clog2(TW);
    localparam int unsigned RW        = $clog2(ROUNDS + 1);
    localparam int unsigned MIX_STEPS = 3 * TW;
    localparam int unsigned SW        = $clog2(MIX_STEPS);
    localparam int unsigned UW        = $clog2(KEY_WORDS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_K_INIT,
        S_MIX_RD,
        S_MIX_A,
        S_MIX_AB,
        S_MIX_B,
        S_E_W1,
        S_E_W2,
        S_E_XA,
        S_E_KA,
        S_E_XB,
        S_E_KB,
        S_D_B,
        S_D_A,
        S_D_F1,
        S_D_F0
    } t_state;

    // Control and key registers.
    t_state                 r_state, n_state;
    logic [KEY_REG_W-1:0]   r_key_low, n_key_low;
    logic [KEY_REG_W-1:0]   r_key_high, n_key_high;
    logic [IW-1:0]          r_n, n_n;
    logic [IW-1:0]          r_t, n_t;
    logic [UW-1:0]          r_u, n_u;
    logic [SW-1:0]          r_step, n_step;
    logic [RW-1:0]          r_r, n_r;
    logic                   r_done, n_done;
    logic [BLOCK_W-1:0]     r_data_out, n_data_out;

    // Datapath registers.
    t_word                  r_a, n_a;
    t_word                  r_b, n_b;
    t_word                  r_ab, n_ab;
    t_word                  r_acc, n_acc;
    t_word                  r_l [KEY_WORDS];
    t_word                  n_l [KEY_WORDS];

    // Round-key table memory with a registered read port.
    t_word                  mem [TW];
    t_word                  r_rdata;
    logic [IW-1:0]          rd_addr;
    logic [IW-1:0]          wr_addr;
    t_word                  wr_data;
    logic                   mem_we;

    // Shared unit hookup.
    t_alu_ctl               alu_ctl;
    t_word                  alu_x, alu_y, alu_z, alu_res;
    logic [ROT_W-1:0]       alu_amt;

    logic                   idle;
    logic                   start_fire;
    logic                   cfg_fire;
    logic [IW-1:0]          idx_even;
    logic [IW-1:0]          idx_odd;
    logic [IW-1:0]          idx_prev;
    t_word                  p_or_acc;

    // A command and a configuration write never land in the same cycle: the command wins.
    assign idle        = (r_state == S_IDLE);
    assign busy        = !idle;
    assign o_cfg_ready = idle && !start;
    assign start_fire  = start && idle;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign o_done      = r_done;
    assign o_data_out  = r_data_out;

    // Round-key addresses of the current round.
    assign idx_even = IW'({r_r, 1'b0});
    assign idx_odd  = IW'({r_r, 1'b1});
    assign idx_prev = idx_even - 1'b1;

    // The first table word is the P constant itself.
    assign p_or_acc = (r_n == '0) ? MAGIC_P : r_acc;

    rc5_alu u_alu (
        .i_ctl (alu_ctl),
        .i_x   (alu_x),
        .i_y   (alu_y),
        .i_z   (alu_z),
        .i_amt (alu_amt),
        .o_res (alu_res)
    );

    always_comb begin
        n_state    = r_state;
        n_key_low  = r_key_low;
        n_key_high = r_key_high;
        n_n        = r_n;
        n_t        = r_t;
        n_u        = r_u;
        n_step     = r_step;
        n_r        = r_r;
        n_done     = 1'b0;
        n_data_out = r_data_out;
        n_a        = r_a;
        n_b        = r_b;
        n_ab       = r_ab;
        n_acc      = r_acc;
        n_l        = r_l;

        alu_ctl.pre       = PRE_ADD;
        alu_ctl.rot_right = 1'b0;
        alu_ctl.post_xor  = 1'b0;
        alu_x             = r_a;
        alu_y             = r_b;
        alu_z             = r_a;
        alu_amt           = '0;

        rd_addr = '0;
        mem_we  = 1'b0;
        wr_addr = r_t;
        wr_data = alu_res;

        unique case (r_state)
            S_IDLE: begin
                // Pre-read the first round key so the first step finds it waiting.
                rd_addr = i_operation ? IW'(TW - 1) : '0;
                if (start_fire) begin
                    n_a = i_data_in[WORD_W-1:0];
                    n_b = i_data_in[BLOCK_W-1:WORD_W];
                    if (i_operation) begin
                        n_r     = RW'(ROUNDS);
                        n_state = S_D_B;
                    end else begin
                        n_r     = RW'(1);
                        n_state = S_E_W1;
                    end
                end else if (cfg_fire) begin
                    // Writes to an unknown index are taken and dropped.
                    if (i_cfg_index == REG_KEY_LOW) begin
                        n_key_low = i_cfg_data;
                        n_n       = '0;
                        n_state   = S_K_INIT;
                    end else if (i_cfg_index == REG_KEY_HIGH) begin
                        n_key_high = i_cfg_data;
                        n_n        = '0;
                        n_state    = S_K_INIT;
                    end
                end
            end

            S_K_INIT: begin
                alu_x   = p_or_acc;
                alu_y   = MAGIC_Q;
                n_acc   = alu_res;
                mem_we  = 1'b1;
                wr_addr = r_n;
                wr_data = p_or_acc;
                if (r_n == '0) begin
                    n_l[0] = r_key_low[WORD_W-1:0];
                    n_l[1] = r_key_low[KEY_REG_W-1:WORD_W];
                    n_l[2] = r_key_high[WORD_W-1:0];
                    n_l[3] = r_key_high[KEY_REG_W-1:WORD_W];
                    n_a    = '0;
                    n_b    = '0;
                end
                if (r_n == IW'(TW - 1)) begin
                    n_t     = '0;
                    n_u     = '0;
                    n_step  = '0;
                    n_state = S_MIX_RD;
                end else begin
                    n_n = r_n + 1'b1;
                end
            end

            S_MIX_RD: begin
                rd_addr = r_t;
                n_ab    = alu_res;
                n_state = S_MIX_A;
            end

            S_MIX_A: begin
                alu_x   = r_rdata;
                alu_y   = r_ab;
                alu_amt = KEY_ROT;
                mem_we  = 1'b1;
                wr_addr = r_t;
                wr_data = alu_res;
                n_a     = alu_res;
                n_state = S_MIX_AB;
            end

            S_MIX_AB: begin
                n_ab    = alu_res;
                n_state = S_MIX_B;
            end

            S_MIX_B: begin
                alu_x    = r_l[r_u];
                alu_y    = r_ab;
                alu_amt  = r_ab[ROT_W-1:0];
                n_b      = alu_res;
                n_l[r_u] = alu_res;
                n_u      = r_u + 1'b1;
                n_t      = (r_t == IW'(TW - 1)) ? '0 : r_t + 1'b1;
                if (r_step == SW'(MIX_STEPS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_step  = r_step + 1'b1;
                    n_state = S_MIX_RD;
                end
            end

            S_E_W1: begin
                alu_x   = r_a;
                alu_y   = r_rdata;
                n_a     = alu_res;
                rd_addr = IW'(1);
                n_state = S_E_W2;
            end

            S_E_W2: begin
                alu_x   = r_b;
                alu_y   = r_rdata;
                n_b     = alu_res;
                rd_addr = idx_even;
                n_state = S_E_XA;
            end

            S_E_XA: begin
                alu_ctl.pre = PRE_XOR;
                alu_x       = r_a;
                alu_y       = r_b;
                alu_amt     = r_b[ROT_W-1:0];
                n_a         = alu_res;
                rd_addr     = idx_even;
                n_state     = S_E_KA;
            end

            S_E_KA: begin
                alu_x   = r_a;
                alu_y   = r_rdata;
                n_a     = alu_res;
                rd_addr = idx_odd;
                n_state = S_E_XB;
            end

            S_E_XB: begin
                alu_ctl.pre = PRE_XOR;
                alu_x       = r_b;
                alu_y       = r_a;
                alu_amt     = r_a[ROT_W-1:0];
                n_b         = alu_res;
                rd_addr     = idx_odd;
                n_state     = S_E_KB;
            end

            S_E_KB: begin
                alu_x = r_b;
                alu_y = r_rdata;
                n_b   = alu_res;
                if (r_r == RW'(ROUNDS)) begin
                    n_done     = 1'b1;
                    n_data_out = {alu_res, r_a};
                    n_state    = S_IDLE;
                end else begin
                    n_r     = r_r + 1'b1;
                    rd_addr = IW'({RW'(r_r + 1'b1), 1'b0});
                    n_state = S_E_XA;
                end
            end

            S_D_B: begin
                alu_ctl.pre       = PRE_SUB;
                alu_ctl.rot_right = 1'b1;
                alu_ctl.post_xor  = 1'b1;
                alu_x             = r_b;
                alu_y             = r_rdata;
                alu_z             = r_a;
                alu_amt           = r_a[ROT_W-1:0];
                n_b               = alu_res;
                rd_addr           = idx_even;
                n_state           = S_D_A;
            end

            S_D_A: begin
                alu_ctl.pre       = PRE_SUB;
                alu_ctl.rot_right = 1'b1;
                alu_ctl.post_xor  = 1'b1;
                alu_x             = r_a;
                alu_y             = r_rdata;
                alu_z             = r_b;
                alu_amt           = r_b[ROT_W-1:0];
                n_a               = alu_res;
                // In the last round this address is the whitening key of word B.
                rd_addr           = idx_prev;
                if (r_r == RW'(1)) begin
                    n_state = S_D_F1;
                end else begin
                    n_r     = r_r - 1'b1;
                    n_state = S_D_B;
                end
            end

            S_D_F1: begin
                alu_ctl.pre = PRE_SUB;
                alu_x       = r_b;
                alu_y       = r_rdata;
                n_b         = alu_res;
                rd_addr     = '0;
                n_state     = S_D_F0;
            end

            S_D_F0: begin
                alu_ctl.pre = PRE_SUB;
                alu_x       = r_a;
                alu_y       = r_rdata;
                n_a         = alu_res;
                n_done      = 1'b1;
                n_data_out  = {r_b, alu_res};
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, key registers, counters and the registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_K_INIT;
            r_key_low  <= '0;
            r_key_high <= '0;
            r_n        <= '0;
            r_t        <= '0;
            r_u        <= '0;
            r_step     <= '0;
            r_r        <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_key_low  <= n_key_low;
            r_key_high <= n_key_high;
            r_n        <= n_n;
            r_t        <= n_t;
            r_u        <= n_u;
            r_step     <= n_step;
            r_r        <= n_r;
            r_done     <= n_done;
            r_data_out <= n_data_out;
        end
    end

    // Working words; every one is loaded before it is used.
    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_ab  <= n_ab;
        r_acc <= n_acc;
        r_l   <= n_l;
    end

    // Round-key table.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/rc5_checker.sv =====
// Port-level checker for the RC5 block cipher and the bind that attaches it.
`default_nettype none

module rc5_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            o_done,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [rc5_pkg::CFG_IDX_W-1:0]   i_cfg_index
);
    import rc5_pkg::*;

    // An accepted command keeps the engine busy on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("command accepted but engine not busy");

    // The result strobe only appears as a transaction finishes.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result strobe outside the end of a transaction");

    // A key write starts a table rebuild.
    a_key_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready &&
        (i_cfg_index == REG_KEY_LOW || i_cfg_index == REG_KEY_HIGH) |=> busy)
        else $error("key write did not start a table rebuild");

    // Configuration is only offered while the engine is idle.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !busy && !start)
        else $error("configuration ready while busy or with a command pending");

endmodule

bind rc5_block_cipher rc5_checker u_rc5_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index)
);

`default_nettype wire

// ===== dv/tb_rc5_block_cipher.sv =====
// Self-checking testbench for the RC5-32/12/16 block cipher top level.
`timescale 1ns / 100ps

module tb_rc5_block_cipher;
    import rc5_pkg::*;

    localparam int unsigned ROUNDS      = ROUNDS_DEF;
    localparam int unsigned SCHED_WORDS = 2 * ROUNDS + 2;
    localparam int unsigned MIX_STEPS   = 3 * SCHED_WORDS;
    localparam int unsigned NUM_PHASES  = 8;
    localparam int unsigned PHASE_ITEMS = 112;
    localparam int unsigned TAIL_CYCLES = 60;

    // Highest configuration index; nothing is mapped there, so writes must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 4'd15;

    // Encrypt/decrypt selector values of i_operation.
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Published RC5-32/12/16 vector for the all-zero key and an all-zero block.
    localparam logic [BLOCK_W-1:0] ZERO_KEY_CIPHERTEXT = 64'h6D8F4B15_EEDBA521;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_operation;
    logic [BLOCK_W-1:0]   i_data_in;
    logic                 o_done;
    logic [BLOCK_W-1:0]   o_data_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [KEY_REG_W-1:0] i_cfg_data;

    rc5_block_cipher #(.ROUNDS(ROUNDS)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_data_in   (i_data_in),
        .o_done      (o_done),
        .o_data_out  (o_data_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Local copy of the key registers and of the round-key table built from them.
    logic [KEY_REG_W-1:0] key_low_copy;
    logic [KEY_REG_W-1:0] key_high_copy;
    t_word                key_schedule [SCHED_WORDS];

    // Expected output blocks, oldest first, one per accepted command transaction.
    logic [BLOCK_W-1:0]   expected_blocks [$];
    logic [BLOCK_W-1:0]   oldest_block;
    int unsigned          mismatch_count;

    // One row of the directed part: when the answer is known by heart it is typed in,
    // otherwise the cipher predictor below supplies it.
    typedef struct {
        logic               op;
        logic [BLOCK_W-1:0] block;
        bit                 answer_known;
        logic [BLOCK_W-1:0] answer;
    } t_directed_row;

    t_directed_row directed_rows [] = '{
        '{OP_ENCRYPT, 64'h0000_0000_0000_0000, 1'b1, ZERO_KEY_CIPHERTEXT},
        '{OP_DECRYPT, ZERO_KEY_CIPHERTEXT,     1'b1, 64'h0000_0000_0000_0000},
        '{OP_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{OP_DECRYPT, 64'h0000_0000_0000_0000, 1'b0, '0},
        '{OP_ENCRYPT, 64'h8000_0000_0000_0000, 1'b0, '0},
        '{OP_ENCRYPT, 64'h0000_0000_0000_0001, 1'b0, '0},
        '{OP_ENCRYPT, 64'h5555_5555_5555_5555, 1'b0, '0},
        '{OP_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
        '{OP_ENCRYPT, 64'hFFFF_FFFF_0000_0000, 1'b0, '0},
        '{OP_ENCRYPT, 64'h0000_0000_FFFF_FFFF, 1'b0, '0},
        '{OP_DECRYPT, 64'h7FFF_FFFF_8000_0000, 1'b0, '0},
        '{OP_ENCRYPT, 64'h0000_0020_0000_0040, 1'b0, '0},
        '{OP_DECRYPT, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
        '{OP_ENCRYPT, ZERO_KEY_CIPHERTEXT,     1'b0, '0}
    };

    // Rotations by a 5-bit amount; doubling the word makes a rotate by zero fall out naturally.
    function automatic t_word rotl32(t_word x, logic [ROT_W-1:0] n);
        logic [2*WORD_W-1:0] doubled;
        doubled = {x, x} << n;
        return doubled[2*WORD_W-1:WORD_W];
    endfunction

    function automatic t_word rotr32(t_word x, logic [ROT_W-1:0] n);
        logic [2*WORD_W-1:0] doubled;
        doubled = {x, x} >> n;
        return doubled[WORD_W-1:0];
    endfunction

    // Rebuild the round-key table from the current key copy: P/Q fill, then the mixing passes.
    function automatic void rebuild_key_schedule();
        t_word       key_words [KEY_WORDS];
        t_word       mix_a;
        t_word       mix_b;
        t_word       amount;
        int unsigned t_idx;
        int unsigned k_idx;
        key_words[0] = key_low_copy[31:0];
        key_words[1] = key_low_copy[63:32];
        key_words[2] = key_high_copy[31:0];
        key_words[3] = key_high_copy[63:32];
        key_schedule[0] = MAGIC_P;
        for (int n = 1; n < SCHED_WORDS; n++) begin
            key_schedule[n] = key_schedule[n-1] + MAGIC_Q;
        end
        mix_a = '0;
        mix_b = '0;
        t_idx = 0;
        k_idx = 0;
        for (int s = 0; s < MIX_STEPS; s++) begin
            mix_a = rotl32(key_schedule[t_idx] + mix_a + mix_b, KEY_ROT);
            key_schedule[t_idx] = mix_a;
            amount = mix_a + mix_b;
            mix_b = rotl32(key_words[k_idx] + mix_a + mix_b, amount[ROT_W-1:0]);
            key_words[k_idx] = mix_b;
            t_idx = (t_idx + 1) % SCHED_WORDS;
            k_idx = (k_idx + 1) % KEY_WORDS;
        end
    endfunction

    // Encrypt or decrypt one block with the current round-key table.
    function automatic logic [BLOCK_W-1:0] cipher_block(logic op, logic [BLOCK_W-1:0] blk);
        t_word word_a;
        t_word word_b;
        word_a = blk[31:0];
        word_b = blk[63:32];
        if (op == OP_ENCRYPT) begin
            word_a = word_a + key_schedule[0];
            word_b = word_b + key_schedule[1];
            for (int r = 1; r <= ROUNDS; r++) begin
                word_a = rotl32(word_a ^ word_b, word_b[ROT_W-1:0]) + key_schedule[2*r];
                word_b = rotl32(word_b ^ word_a, word_a[ROT_W-1:0]) + key_schedule[2*r+1];
            end
        end else begin
            for (int r = ROUNDS; r >= 1; r--) begin
                word_b = rotr32(word_b - key_schedule[2*r+1], word_a[ROT_W-1:0]) ^ word_a;
                word_a = rotr32(word_a - key_schedule[2*r], word_b[ROT_W-1:0]) ^ word_b;
            end
            word_b = word_b - key_schedule[1];
            word_a = word_a - key_schedule[0];
        end
        return {word_b, word_a};
    endfunction

    // Random blocks lean toward the corners: all-zero or all-one halves, and a B word whose
    // low five bits are clear.
    function automatic logic [BLOCK_W-1:0] random_block();
        logic [BLOCK_W-1:0] blk;
        blk = {$urandom, $urandom};
        case ($urandom_range(9))
            0: blk[31:0]  = '0;
            1: blk[63:32] = '1;
            2: blk[36:32] = '0;
            3: blk        = $urandom_range(1) ? '1 : '0;
            default: ;
        endcase
        return blk;
    endfunction

    task automatic report_mismatch(string what, logic [BLOCK_W-1:0] got,
                                   logic [BLOCK_W-1:0] want);
        $display("MISMATCH %s at %0t ns: got %h, expected %h", what, $time, got, want);
        mismatch_count++;
    endtask

    // Present one command and hold it until the block takes it; the expected block is
    // queued at the edge where the transaction is accepted.
    task automatic send_block(logic op, logic [BLOCK_W-1:0] blk, bit answer_known,
                              logic [BLOCK_W-1:0] answer);
        @(negedge i_clk);
        start       <= 1'b1;
        i_operation <= op;
        i_data_in   <= blk;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        expected_blocks.push_back(answer_known ? answer : cipher_block(op, blk));
    endtask

    // Drop start and wait until every outstanding result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
    endtask

    // One configuration transaction. Key writes rebuild the local table as the block does;
    // writes to unmapped indexes leave everything alone.
    task automatic write_key_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_REG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            REG_KEY_LOW: begin
                key_low_copy = value;
                rebuild_key_schedule();
            end
            REG_KEY_HIGH: begin
                key_high_copy = value;
                rebuild_key_schedule();
            end
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random command transactions. With idle_pct above zero the sender sits out a random
    // stretch before some commands, so start rises at every point of the block's busy window.
    task automatic run_random_blocks(int unsigned count, int unsigned idle_pct,
                                     bit drain_midway);
        int unsigned gap;
        for (int unsigned i = 0; i < count; i++) begin
            if (drain_midway && i == count / 2) begin
                drain_results();
            end else if ($urandom_range(99) < idle_pct) begin
                gap = $urandom_range(60, 1);
                @(negedge i_clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            send_block(logic'($urandom_range(1)), random_block(), 1'b0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Results cannot be stalled: every o_done cycle is a transaction and is checked here.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_blocks.size() == 0) begin
                report_mismatch("result with nothing outstanding", o_data_out, '0);
            end else begin
                oldest_block = expected_blocks.pop_front();
                if (o_data_out !== oldest_block) begin
                    report_mismatch("data_out", o_data_out, oldest_block);
                end
            end
        end
    end

    initial begin
        int unsigned idle_pct;

        mismatch_count = 0;
        start          = 1'b0;
        i_operation    = OP_ENCRYPT;
        i_data_in      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = REG_KEY_LOW;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;

        // Reset leaves the table expanded from the all-zero key.
        key_low_copy  = '0;
        key_high_copy = '0;
        rebuild_key_schedule();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, back to back, on the reset key. The block is still rebuilding its
        // table after reset, so the first command simply waits for busy to drop.
        foreach (directed_rows[i]) begin
            send_block(directed_rows[i].op, directed_rows[i].block,
                       directed_rows[i].answer_known, directed_rows[i].answer);
        end

        // Random phases. Each one starts from an idle block after its own key writes, then
        // runs its share of commands under its own sender idling.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    // Writing back the values reset already holds must change nothing.
                    write_key_reg(REG_KEY_LOW, '0);
                    write_key_reg(REG_KEY_HIGH, '0);
                end
                1: begin
                    write_key_reg(REG_KEY_LOW, '1);
                    write_key_reg(REG_KEY_HIGH, '1);
                end
                2: begin
                    write_key_reg(REG_KEY_LOW, 64'h51B241BE_19465F91);
                    write_key_reg(REG_KEY_HIGH, 64'h91CEA910_01A55563);
                end
                3: begin
                    write_key_reg(REG_KEY_LOW, {$urandom, $urandom});
                    write_key_reg(REG_KEY_HIGH, {$urandom, $urandom});
                    write_key_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_TOP, 2)),
                                  {$urandom, $urandom});
                end
                4: write_key_reg(REG_KEY_LOW, {$urandom, $urandom});
                5: begin
                    write_key_reg(REG_KEY_HIGH, {$urandom, $urandom});
                    write_key_reg(REG_UNUSED_TOP, '1);
                end
                6: begin
                    write_key_reg(REG_KEY_HIGH, {$urandom, $urandom});
                    write_key_reg(REG_KEY_LOW, {$urandom, $urandom});
                    write_key_reg(REG_KEY_LOW, key_low_copy);
                end
                default: begin
                    write_key_reg(REG_KEY_LOW, '0);
                    write_key_reg(REG_KEY_HIGH, '1);
                end
            endcase
            case (phase % 4)
                0: idle_pct = 0;
                1: idle_pct = 64;
                2: idle_pct = 34;
                default: idle_pct = 64;
            endcase
            run_random_blocks(PHASE_ITEMS, idle_pct, phase == 1);
        end

        // Let the last transactions come back, bounded by the slowest command.
        @(negedge i_clk);
        start <= 1'b0;
        for (int c = 0; c < 4 * SCHED_WORDS && expected_blocks.size() != 0; c++) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_blocks.size() != 0) begin
            report_mismatch("result never arrived", '0, expected_blocks[0]);
        end

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rc5_pkg.sv
rtl/core/rc5_alu.sv
rtl/core/rc5_block_cipher.sv
rtl/core/rc5_checker.sv
dv/tb_rc5_block_cipher.sv
